@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the macroblock reconstruction RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An antecedent that holds implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// An antecedent that holds implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// A condition that must never hold.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition");

`endif

@@ rtl/mmcr_pkg.sv @@
// ---------------------------------------------------------------------------
// mmcr_pkg
// Constants and types shared by the macroblock reconstruction modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmcr_pkg;

    // Address and lane geometry.
    localparam int ADDR_BITS        = 22;
    localparam int LANES            = 4;
    localparam int WIDTH_BITS       = 13;
    localparam int NUM_BLOCKS       = 6;
    localparam int BLOCK_PIXELS     = 64;
    localparam int GROUPS_PER_BLOCK = BLOCK_PIXELS / LANES;
    localparam int GROUP_BITS       = $clog2(GROUPS_PER_BLOCK + 1);
    localparam int BLK_BITS         = 3;
    localparam int PIX_BITS         = 8;
    localparam int RES_BITS         = 16;

    // Fixed values used by the address generator and the lanes.
    localparam logic [BLK_BITS-1:0]   LAST_BLOCK   = BLK_BITS'(NUM_BLOCKS - 1);
    localparam logic [BLK_BITS-1:0]   FIRST_CHROMA = BLK_BITS'(4);
    localparam logic [PIX_BITS-1:0]   PIX_MAX      = 8'd255;
    localparam logic [ADDR_BITS-1:0]  BLOCK_STEP   = ADDR_BITS'(8);
    localparam logic [GROUP_BITS-1:0] GROUP_LAST   = GROUP_BITS'(GROUPS_PER_BLOCK - 1);

    // Result kinds.
    localparam logic KIND_FETCH = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // Input commands.
    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_DATA   = 1'b1;

    // Configuration register indexes and reset value.
    localparam logic REG_LUMA_WIDTH = 1'b0;
    localparam logic [WIDTH_BITS-1:0] LUMA_WIDTH_RESET = 13'd352;

    // Fetch result offered by the address generator to the output stage.
    typedef struct packed {
        logic                  active;
        logic                  fire;
        logic [BLK_BITS-1:0]   index;
        logic [ADDR_BITS-1:0]  address;
        logic [WIDTH_BITS-1:0] stride;
        logic                  last;
    } fetch_t;

endpackage

@@ rtl/mmcr_lane.sv @@
// ---------------------------------------------------------------------------
// mmcr_lane
// One pixel lane: adds a signed residual to a predictor byte and saturates.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmcr_lane (
    input  logic [mmcr_pkg::PIX_BITS-1:0]        pred,
    input  logic signed [mmcr_pkg::RES_BITS-1:0] residual,
    input  logic                                 coded,
    output logic [mmcr_pkg::PIX_BITS-1:0]        pixel
);
    import mmcr_pkg::*;

    logic signed [RES_BITS:0] sum;

    // Sum is one bit wider than the residual so it cannot overflow.
    assign sum = $signed({{(RES_BITS - PIX_BITS + 1){1'b0}}, pred})
               + $signed({residual[RES_BITS-1], residual});

    // Saturate to the pixel range for coded blocks; pass the predictor otherwise.
    always_comb begin
        if (!coded) begin
            pixel = pred;
        end else if (sum[RES_BITS]) begin
            pixel = '0;
        end else if (sum[RES_BITS-1:PIX_BITS] != '0) begin
            pixel = PIX_MAX;
        end else begin
            pixel = sum[PIX_BITS-1:0];
        end
    end

endmodule

@@ rtl/mmcr_addr_gen.sv @@
// ---------------------------------------------------------------------------
// mmcr_addr_gen
// Computes motion-shifted block addresses and emits six fetch results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmcr_addr_gen (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  hdr_load,
    input  logic [mmcr_pkg::ADDR_BITS-1:0]        luma_base,
    input  logic [mmcr_pkg::ADDR_BITS-1:0]        chroma_base,
    input  logic signed [5:0]                     motion_x,
    input  logic signed [5:0]                     motion_y,
    input  logic [mmcr_pkg::WIDTH_BITS-1:0]       luma_width,
    input  logic                                  out_free,
    output mmcr_pkg::fetch_t                      fetch
);
    import mmcr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [BLK_BITS-1:0]     idx_reg;
    logic [ADDR_BITS-1:0]    luma_addr_reg;
    logic [ADDR_BITS-1:0]    chroma_addr_reg;
    logic [WIDTH_BITS-1:0]   width_reg;

    logic signed [WIDTH_BITS+6:0]  luma_prod;
    logic signed [WIDTH_BITS+5:0]  chroma_prod;
    logic signed [5:0]             half_x;
    logic signed [5:0]             half_y;
    logic [ADDR_BITS-1:0]          luma_addr_next;
    logic [ADDR_BITS-1:0]          chroma_addr_next;
    logic [ADDR_BITS-1:0]          row_offset;
    logic [ADDR_BITS-1:0]          col_offset;

    // Chroma vector is the luma vector halved with truncation toward zero.
    assign half_x = (motion_x + $signed({5'b0, motion_x[5]})) >>> 1;
    assign half_y = (motion_y + $signed({5'b0, motion_y[5]})) >>> 1;

    // Vertical displacement products; addresses wrap modulo 2^ADDR_BITS.
    assign luma_prod   = motion_y * $signed({1'b0, luma_width});
    assign chroma_prod = half_y * $signed({1'b0, luma_width[WIDTH_BITS-1:1]});

    assign luma_addr_next   = luma_base + ADDR_BITS'(luma_prod) + ADDR_BITS'(motion_x);
    assign chroma_addr_next = chroma_base + ADDR_BITS'(chroma_prod) + ADDR_BITS'(half_x);

    // Lower luma blocks sit eight rows down, right blocks eight pixels over.
    assign row_offset = idx_reg[1] ? ADDR_BITS'({width_reg, 3'b000}) : '0;
    assign col_offset = idx_reg[0] ? BLOCK_STEP : '0;

    // Fetch result for the current block.
    always_comb begin
        fetch.active = (state_reg == ST_EMIT);
        fetch.fire   = (state_reg == ST_EMIT) && out_free;
        fetch.index  = idx_reg;
        fetch.last   = (idx_reg == LAST_BLOCK);
        if (idx_reg < FIRST_CHROMA) begin
            fetch.address = luma_addr_reg + row_offset + col_offset;
            fetch.stride  = width_reg;
        end else begin
            fetch.address = chroma_addr_reg;
            fetch.stride  = {1'b0, width_reg[WIDTH_BITS-1:1]};
        end
    end

    // Sequencer: load on a header, then step through the six blocks.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (hdr_load) begin
                        state_reg       <= ST_EMIT;
                        idx_reg         <= '0;
                        luma_addr_reg   <= luma_addr_next;
                        chroma_addr_reg <= chroma_addr_next;
                        width_reg       <= luma_width;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        if (idx_reg == LAST_BLOCK) begin
                            state_reg <= ST_IDLE;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/macroblock_motion_comp_reconstruct.sv @@
// Macroblock motion-compensated reconstruction, 4:2:0.
// The input channel (s_*) carries two kinds of transfer. A header (cmd 0)
// gives the macroblock luma and chroma offsets, the full-pel motion vector
// and the coded-block mask; it yields six fetch results on the output
// channel (m_*), one per block, with the predictor start address and the
// row stride. A data transfer (cmd 1) carries four predictor bytes and four
// signed residuals and yields one group of four reconstructed pixels.
// Data groups run 16 per block, blocks 0..5 in order; m_last marks the
// sixth fetch result and the 96th group.
// A pixel group is registered at the edge of its input transfer and can be
// taken in the cycle after it. A header loads the address sequencer, which
// then hands its fetch results to the output register in block order, one
// per cycle while the receiver does not stall; s_ready stays low until the
// sixth is handed over. Data groups sustain one per cycle while the receiver
// does not stall. When the receiver stalls, the output register holds its
// result and s_ready drops; nothing is lost. Reset clears the group count
// and the coded flags (all blocks pass the predictor) and sets luma_width to
// 352. The APB port writes luma_width at byte addresses 0 to 3 (paddr[2]
// clear); pready is always high.
// ---------------------------------------------------------------------------
// macroblock_motion_comp_reconstruct
// Top level: input control, address sequencer, pixel lanes and output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module macroblock_motion_comp_reconstruct (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    // Configuration port
    input  logic                                             psel,
    input  logic                                             penable,
    input  logic                                             pwrite,
    input  logic [2:0]                                       paddr,
    input  logic [31:0]                                      pwdata,
    output logic [31:0]                                      prdata,
    output logic                                             pready,
    // Input channel
    input  logic                                             s_valid,
    output logic                                             s_ready,
    input  logic                                             s_cmd,
    input  logic [mmcr_pkg::ADDR_BITS-1:0]                   s_luma_base,
    input  logic [mmcr_pkg::ADDR_BITS-1:0]                   s_chroma_base,
    input  logic signed [5:0]                                s_motion_x,
    input  logic signed [5:0]                                s_motion_y,
    input  logic [5:0]                                       s_coded_mask,
    input  logic [mmcr_pkg::LANES*mmcr_pkg::PIX_BITS-1:0]    s_pred_bytes,
    input  logic [mmcr_pkg::LANES*mmcr_pkg::RES_BITS-1:0]    s_residual_words,
    // Result channel
    output logic                                             m_valid,
    input  logic                                             m_ready,
    output logic                                             m_out_kind,
    output logic [mmcr_pkg::BLK_BITS-1:0]                    m_block_index,
    output logic [mmcr_pkg::ADDR_BITS-1:0]                   m_fetch_address,
    output logic [mmcr_pkg::WIDTH_BITS-1:0]                  m_row_stride,
    output logic [mmcr_pkg::LANES*mmcr_pkg::PIX_BITS-1:0]    m_pixels,
    output logic                                             m_last
);
    import mmcr_pkg::*;

    logic [WIDTH_BITS-1:0]        luma_width_reg;
    logic [5:0]                   coded_flags_reg;
    logic [BLK_BITS-1:0]          blk_reg;
    logic [GROUP_BITS-1:0]        grp_reg;

    logic                         m_valid_reg;
    logic                         m_kind_reg;
    logic [BLK_BITS-1:0]          m_block_reg;
    logic [ADDR_BITS-1:0]         m_addr_reg;
    logic [WIDTH_BITS-1:0]        m_stride_reg;
    logic [LANES*PIX_BITS-1:0]    m_pixels_reg;
    logic                         m_last_reg;

    logic                         out_free;
    logic                         in_xfer;
    logic                         hdr_xfer;
    logic                         data_xfer;
    logic                         blk_coded;
    logic                         group_last;
    logic [LANES*PIX_BITS-1:0]    lane_pixels;
    fetch_t                       fetch;

    // Configuration register; single register at byte addresses 0 to 3 (paddr[2] clear).
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LUMA_WIDTH) ? {{(32 - WIDTH_BITS){1'b0}}, luma_width_reg}
                                                 : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            luma_width_reg <= LUMA_WIDTH_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LUMA_WIDTH)) begin
            luma_width_reg <= pwdata[WIDTH_BITS-1:0];
        end
    end

    // Input handshake: the output register must be free and no header in flight.
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = out_free && !fetch.active;
    assign in_xfer   = s_valid && s_ready;
    assign hdr_xfer  = in_xfer && (s_cmd == CMD_HEADER);
    assign data_xfer = in_xfer && (s_cmd == CMD_DATA);

    // Address sequencer for the six predictor blocks.
    mmcr_addr_gen u_addr_gen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hdr_load    (hdr_xfer),
        .luma_base   (s_luma_base),
        .chroma_base (s_chroma_base),
        .motion_x    (s_motion_x),
        .motion_y    (s_motion_y),
        .luma_width  (luma_width_reg),
        .out_free    (out_free),
        .fetch       (fetch)
    );

    // Block position of the current data group; bit 5-k of the mask codes block k.
    assign blk_coded  = coded_flags_reg[LAST_BLOCK - blk_reg];
    assign group_last = (grp_reg == GROUP_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coded_flags_reg <= '0;
            blk_reg         <= '0;
            grp_reg         <= '0;
        end else if (hdr_xfer) begin
            coded_flags_reg <= s_coded_mask;
            blk_reg         <= '0;
            grp_reg         <= '0;
        end else if (data_xfer) begin
            if (group_last) begin
                grp_reg <= '0;
                blk_reg <= (blk_reg == LAST_BLOCK) ? '0 : blk_reg + 1'b1;
            end else begin
                grp_reg <= grp_reg + 1'b1;
            end
        end
    end

    // Pixel lanes work side by side on the four pixels of a group.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        mmcr_lane u_lane (
            .pred     (s_pred_bytes[l*PIX_BITS +: PIX_BITS]),
            .residual ($signed(s_residual_words[l*RES_BITS +: RES_BITS])),
            .coded    (blk_coded),
            .pixel    (lane_pixels[l*PIX_BITS +: PIX_BITS])
        );
    end

    // Output stage merges the lanes or takes a fetch result from the sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fetch.fire || data_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fetch.fire) begin
            m_kind_reg   <= KIND_FETCH;
            m_block_reg  <= fetch.index;
            m_addr_reg   <= fetch.address;
            m_stride_reg <= fetch.stride;
            m_pixels_reg <= '0;
            m_last_reg   <= fetch.last;
        end else if (data_xfer) begin
            m_kind_reg   <= KIND_PIXEL;
            m_block_reg  <= blk_reg;
            m_addr_reg   <= '0;
            m_stride_reg <= '0;
            m_pixels_reg <= lane_pixels;
            m_last_reg   <= group_last && (blk_reg == LAST_BLOCK);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_kind      = m_kind_reg;
    assign m_block_index   = m_block_reg;
    assign m_fetch_address = m_addr_reg;
    assign m_row_stride    = m_stride_reg;
    assign m_pixels        = m_pixels_reg;
    assign m_last          = m_last_reg;

    // Checks on the sequencing of headers, fetch results and data groups.
    `ASSERT_NEVER(a_no_input_during_fetch, aclk, aresetn, s_ready && fetch.active)
    `ASSERT_NEXT(a_header_starts_fetch, aclk, aresetn, hdr_xfer, fetch.active && (fetch.index == '0))
    `ASSERT_IMPLIES(a_fetch_last_on_v, aclk, aresetn, m_valid && (m_out_kind == KIND_FETCH), m_last == (m_block_index == LAST_BLOCK))
    `ASSERT_IMPLIES(a_block_in_range, aclk, aresetn, m_valid, m_block_index <= LAST_BLOCK)

endmodule
